### hdl/plt_pkg.sv
// Shared constants, types and codes for the point light tile tint block.
package plt_pkg;

    // Map geometry.
    localparam int TILE_SIZE = 128;
    localparam int MAP_SIDE  = 256;

    // Field widths.
    localparam int COL_W    = 8;
    localparam int ROW_W    = 8;
    localparam int HGT_W    = 14;
    localparam int CH_W     = 8;
    localparam int LX_W     = 15;
    localparam int LH_W     = 14;
    localparam int LZ_W     = 15;
    localparam int RNG_W    = 15;
    localparam int COLOUR_W = 3;

    // Configuration port.
    localparam int CFG_W      = 15;
    localparam int CFG_ADDR_W = 3;

    localparam logic [CFG_ADDR_W-1:0] CFG_LIGHT_X      = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_LIGHT_HEIGHT = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_LIGHT_Z      = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_LIGHT_RANGE  = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] CFG_LIGHT_COLOUR = 3'd4;

    localparam logic [COLOUR_W-1:0] COLOUR_RED    = 3'd0;
    localparam logic [COLOUR_W-1:0] COLOUR_GREEN  = 3'd1;
    localparam logic [COLOUR_W-1:0] COLOUR_BLUE   = 3'd2;
    localparam logic [COLOUR_W-1:0] COLOUR_YELLOW = 3'd3;
    localparam logic [COLOUR_W-1:0] COLOUR_WHITE  = 3'd4;

    // Attenuation arithmetic.
    localparam int ATTEN_SCALE = 100;
    localparam int TINT_GAIN   = 2;
    localparam int CH_MAX      = 255;

    // Corner positions and distance widths.
    localparam int POS_X_MAX = ((1 << COL_W) - 1) * TILE_SIZE;
    localparam int POS_Z_MAX = ((1 << ROW_W) - 1) * TILE_SIZE;
    localparam int POS_X_W   = $clog2(POS_X_MAX + 1);
    localparam int POS_Z_W   = $clog2(POS_Z_MAX + 1);
    localparam int DX_W      = (POS_X_W > LX_W) ? POS_X_W : LX_W;
    localparam int DZ_W      = (POS_Z_W > LZ_W) ? POS_Z_W : LZ_W;
    localparam int DY_W      = (HGT_W > LH_W) ? HGT_W : LH_W;

    localparam longint unsigned SUM_MAX =
        ((longint'(1) << DX_W) - 1) * ((longint'(1) << DX_W) - 1) +
        ((longint'(1) << DY_W) - 1) * ((longint'(1) << DY_W) - 1) +
        ((longint'(1) << DZ_W) - 1) * ((longint'(1) << DZ_W) - 1);
    localparam int SUM_W = $clog2(SUM_MAX + 1);

    // Square root: two root bits per stage.
    localparam int SQ_N      = (SUM_W + 1) / 2;
    localparam int SQ_W      = 2 * SQ_N;
    localparam int SQ_STAGES = (SQ_N + 1) / 2;
    localparam int DIST_W    = SQ_N;

    // Divider: the quotient stays below ATTEN_SCALE while the corner is in range.
    localparam int Q_W       = $clog2(ATTEN_SCALE);
    localparam int DV_W      = RNG_W + Q_W;
    localparam int DV_STAGES = (Q_W + 1) / 2;
    localparam int ADD_W     = $clog2(TINT_GAIN * ATTEN_SCALE + 1);

    // Stream widths.
    localparam int S_TDATA_W = 56;
    localparam int M_TDATA_W = 32;

    // Register stages from input to output register.
    localparam int PIPE_DEPTH = 3 + SQ_STAGES + 1 + DV_STAGES + 1;

    typedef struct packed {
        logic [LX_W-1:0]     light_x;
        logic [LH_W-1:0]     light_height;
        logic [LZ_W-1:0]     light_z;
        logic [RNG_W-1:0]    light_range;
        logic [COLOUR_W-1:0] light_hue;
    } light_t;

    // live starts as the on-map test and is cleared later when out of range.
    typedef struct packed {
        logic            live;
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
    } tile_t;

endpackage

### hdl/plt_dist.sv
// Corner position, axis differences, squares and squared distance in three stages.
module plt_dist (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  plt_pkg::light_t             light,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [plt_pkg::COL_W-1:0]   in_col,
    input  logic [plt_pkg::ROW_W-1:0]   in_row,
    input  logic [plt_pkg::HGT_W-1:0]   in_height,
    input  plt_pkg::tile_t              in_tile,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [plt_pkg::SUM_W-1:0]   out_sum,
    output plt_pkg::tile_t              out_tile
);

    logic                       v1_reg, v2_reg, v3_reg;
    logic                       rdy1, rdy2, rdy3;
    logic [plt_pkg::DX_W-1:0]   dx_reg;
    logic [plt_pkg::DY_W-1:0]   dy_reg;
    logic [plt_pkg::DZ_W-1:0]   dz_reg;
    plt_pkg::tile_t             t1_reg, t2_reg, t3_reg;
    logic [plt_pkg::SUM_W-1:0]  sqx_reg, sqy_reg, sqz_reg, sum_reg;
    logic [plt_pkg::DX_W-1:0]   pos_x, lx, dx_next;
    logic [plt_pkg::DZ_W-1:0]   pos_z, lz, dz_next;
    logic [plt_pkg::DY_W-1:0]   hy, ly, dy_next;
    plt_pkg::tile_t             t1_next;

    assign rdy3     = !v3_reg || out_ready;
    assign rdy2     = !v2_reg || rdy3;
    assign rdy1     = !v1_reg || rdy2;
    assign in_ready = rdy1;

    always_comb begin
        pos_x = plt_pkg::DX_W'(32'(in_col) * plt_pkg::TILE_SIZE);
        pos_z = plt_pkg::DZ_W'(32'(in_row) * plt_pkg::TILE_SIZE);
        lx    = plt_pkg::DX_W'(light.light_x);
        lz    = plt_pkg::DZ_W'(light.light_z);
        hy    = plt_pkg::DY_W'(in_height);
        ly    = plt_pkg::DY_W'(light.light_height);
        dx_next = (pos_x > lx) ? (pos_x - lx) : (lx - pos_x);
        dz_next = (pos_z > lz) ? (pos_z - lz) : (lz - pos_z);
        dy_next = (hy > ly) ? (hy - ly) : (ly - hy);
        t1_next = in_tile;
        t1_next.live = (32'(in_col) < plt_pkg::MAP_SIDE) && (32'(in_row) < plt_pkg::MAP_SIDE);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            if (rdy1) v1_reg <= in_valid;
            if (rdy2) v2_reg <= v1_reg;
            if (rdy3) v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy1 && in_valid) begin
            dx_reg <= dx_next;
            dy_reg <= dy_next;
            dz_reg <= dz_next;
            t1_reg <= t1_next;
        end
        if (rdy2 && v1_reg) begin
            sqx_reg <= plt_pkg::SUM_W'(dx_reg) * plt_pkg::SUM_W'(dx_reg);
            sqy_reg <= plt_pkg::SUM_W'(dy_reg) * plt_pkg::SUM_W'(dy_reg);
            sqz_reg <= plt_pkg::SUM_W'(dz_reg) * plt_pkg::SUM_W'(dz_reg);
            t2_reg  <= t1_reg;
        end
        if (rdy3 && v2_reg) begin
            sum_reg <= sqx_reg + sqy_reg + sqz_reg;
            t3_reg  <= t2_reg;
        end
    end

    assign out_valid = v3_reg;
    assign out_sum   = sum_reg;
    assign out_tile  = t3_reg;

endmodule

### hdl/plt_sqrt.sv
// Pipelined floor square root, two root bits resolved in each stage.
module plt_sqrt (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [plt_pkg::SUM_W-1:0]   in_sum,
    input  plt_pkg::tile_t              in_tile,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [plt_pkg::DIST_W-1:0]  out_dist,
    output plt_pkg::tile_t              out_tile
);

    localparam int NST = plt_pkg::SQ_STAGES;
    localparam int W   = plt_pkg::SQ_W;

    logic           valid_reg [NST];
    logic           stage_rdy [NST];
    logic [W-1:0]   rem_reg   [NST];
    logic [W-1:0]   res_reg   [NST];
    plt_pkg::tile_t tile_reg  [NST];
    logic           src_valid [NST];
    logic [W-1:0]   src_rem   [NST];
    logic [W-1:0]   src_res   [NST];
    plt_pkg::tile_t src_tile  [NST];
    logic [W-1:0]   rem_next  [NST];
    logic [W-1:0]   res_next  [NST];

    always_comb begin
        src_valid[0] = in_valid;
        src_rem[0]   = W'(in_sum);
        src_res[0]   = '0;
        src_tile[0]  = in_tile;
        for (int g = 1; g < NST; g++) begin
            src_valid[g] = valid_reg[g-1];
            src_rem[g]   = rem_reg[g-1];
            src_res[g]   = res_reg[g-1];
            src_tile[g]  = tile_reg[g-1];
        end
    end

    // A stage may load when it is empty or its word moves on in the same cycle.
    always_comb begin
        stage_rdy[NST-1] = !valid_reg[NST-1] || out_ready;
        for (int g = NST - 2; g >= 0; g--) begin
            stage_rdy[g] = !valid_reg[g] || stage_rdy[g+1];
        end
    end

    assign in_ready = stage_rdy[0];

    // Digit-by-digit root with the bit weight fixed by the iteration number.
    always_comb begin
        logic [W-1:0] rem;
        logic [W-1:0] res;
        logic [W-1:0] bitv;
        logic [W:0]   trial;
        int           it;
        for (int g = 0; g < NST; g++) begin
            rem = src_rem[g];
            res = src_res[g];
            for (int j = 0; j < 2; j++) begin
                it = 2 * g + j;
                if (it < plt_pkg::SQ_N) begin
                    bitv  = W'(1) << (2 * (plt_pkg::SQ_N - 1 - it));
                    trial = {1'b0, res} + {1'b0, bitv};
                    if ({1'b0, rem} >= trial) begin
                        rem = rem - trial[W-1:0];
                        res = (res >> 1) + bitv;
                    end else begin
                        res = res >> 1;
                    end
                end
            end
            rem_next[g] = rem;
            res_next[g] = res;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int g = 0; g < NST; g++) valid_reg[g] <= 1'b0;
        end else begin
            for (int g = 0; g < NST; g++) begin
                if (stage_rdy[g]) valid_reg[g] <= src_valid[g];
            end
        end
    end

    always_ff @(posedge aclk) begin
        for (int g = 0; g < NST; g++) begin
            if (stage_rdy[g] && src_valid[g]) begin
                rem_reg[g]  <= rem_next[g];
                res_reg[g]  <= res_next[g];
                tile_reg[g] <= src_tile[g];
            end
        end
    end

    assign out_valid = valid_reg[NST-1];
    assign out_dist  = res_reg[NST-1][plt_pkg::DIST_W-1:0];
    assign out_tile  = tile_reg[NST-1];

endmodule

### hdl/plt_quot.sv
// Range test, pipelined attenuation divide and saturating tint into the output register.
module plt_quot (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  plt_pkg::light_t             light,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [plt_pkg::DIST_W-1:0]  in_dist,
    input  plt_pkg::tile_t              in_tile,
    output logic                        out_valid,
    input  logic                        out_ready,
    output plt_pkg::tile_t              out_tile
);

    localparam int NST = plt_pkg::DV_STAGES;
    localparam int W   = plt_pkg::DV_W;
    localparam int QW  = plt_pkg::Q_W;

    function automatic logic [plt_pkg::CH_W-1:0] sat_add(
        input logic [plt_pkg::CH_W-1:0]  c,
        input logic [plt_pkg::ADD_W-1:0] a
    );
        logic [plt_pkg::CH_W+plt_pkg::ADD_W-1:0] s;
        s = (plt_pkg::CH_W + plt_pkg::ADD_W)'(c) + (plt_pkg::CH_W + plt_pkg::ADD_W)'(a);
        if (32'(s) > plt_pkg::CH_MAX) begin
            return plt_pkg::CH_W'(plt_pkg::CH_MAX);
        end
        return s[plt_pkg::CH_W-1:0];
    endfunction

    logic           a_valid_reg, a_rdy;
    logic [W-1:0]   a_num_reg;
    plt_pkg::tile_t a_tile_reg;
    plt_pkg::tile_t a_tile_next;

    logic           valid_reg [NST];
    logic           stage_rdy [NST];
    logic [W-1:0]   rem_reg   [NST];
    logic [QW-1:0]  q_reg     [NST];
    plt_pkg::tile_t tile_reg  [NST];
    logic           src_valid [NST];
    logic [W-1:0]   src_rem   [NST];
    logic [QW-1:0]  src_q     [NST];
    plt_pkg::tile_t src_tile  [NST];
    logic [W-1:0]   rem_next  [NST];
    logic [QW-1:0]  q_next    [NST];

    logic                       o_valid_reg, o_rdy;
    plt_pkg::tile_t             o_tile_reg, o_tile_next;
    logic [plt_pkg::ADD_W-1:0]  add;
    logic [2:0]                 chan_mask;

    // Handshake chain from the output register back to the range test.
    always_comb begin
        o_rdy = !o_valid_reg || out_ready;
        stage_rdy[NST-1] = !valid_reg[NST-1] || o_rdy;
        for (int g = NST - 2; g >= 0; g--) begin
            stage_rdy[g] = !valid_reg[g] || stage_rdy[g+1];
        end
        a_rdy = !a_valid_reg || stage_rdy[0];
    end

    assign in_ready = a_rdy;

    // The scaled distance is only meaningful while the corner is in range.
    always_comb begin
        a_tile_next = in_tile;
        a_tile_next.live = in_tile.live && (32'(in_dist) < 32'(light.light_range));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
        end else if (a_rdy) begin
            a_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (a_rdy && in_valid) begin
            a_num_reg  <= W'(32'(in_dist) * plt_pkg::ATTEN_SCALE);
            a_tile_reg <= a_tile_next;
        end
    end

    always_comb begin
        src_valid[0] = a_valid_reg;
        src_rem[0]   = a_num_reg;
        src_q[0]     = '0;
        src_tile[0]  = a_tile_reg;
        for (int g = 1; g < NST; g++) begin
            src_valid[g] = valid_reg[g-1];
            src_rem[g]   = rem_reg[g-1];
            src_q[g]     = q_reg[g-1];
            src_tile[g]  = tile_reg[g-1];
        end
    end

    // Restoring division, most significant quotient bit first.
    always_comb begin
        logic [W-1:0]  rem;
        logic [QW-1:0] q;
        logic [W-1:0]  dvs;
        int            it;
        for (int g = 0; g < NST; g++) begin
            rem = src_rem[g];
            q   = src_q[g];
            for (int j = 0; j < 2; j++) begin
                it = 2 * g + j;
                if (it < QW) begin
                    dvs = W'(light.light_range) << (QW - 1 - it);
                    if (rem >= dvs) begin
                        rem = rem - dvs;
                        q[QW-1-it] = 1'b1;
                    end
                end
            end
            rem_next[g] = rem;
            q_next[g]   = q;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int g = 0; g < NST; g++) valid_reg[g] <= 1'b0;
        end else begin
            for (int g = 0; g < NST; g++) begin
                if (stage_rdy[g]) valid_reg[g] <= src_valid[g];
            end
        end
    end

    always_ff @(posedge aclk) begin
        for (int g = 0; g < NST; g++) begin
            if (stage_rdy[g] && src_valid[g]) begin
                rem_reg[g]  <= rem_next[g];
                q_reg[g]    <= q_next[g];
                tile_reg[g] <= src_tile[g];
            end
        end
    end

    always_comb begin
        add = plt_pkg::ADD_W'(plt_pkg::TINT_GAIN *
                              (plt_pkg::ATTEN_SCALE - int'(q_reg[NST-1])));
        case (light.light_hue)
            plt_pkg::COLOUR_RED:    chan_mask = 3'b001;
            plt_pkg::COLOUR_GREEN:  chan_mask = 3'b010;
            plt_pkg::COLOUR_BLUE:   chan_mask = 3'b100;
            plt_pkg::COLOUR_YELLOW: chan_mask = 3'b011;
            plt_pkg::COLOUR_WHITE:  chan_mask = 3'b111;
            default:                chan_mask = 3'b000;
        endcase
        if (!tile_reg[NST-1].live) chan_mask = 3'b000;
        o_tile_next       = tile_reg[NST-1];
        o_tile_next.red   = chan_mask[0] ? sat_add(tile_reg[NST-1].red, add)
                                         : tile_reg[NST-1].red;
        o_tile_next.green = chan_mask[1] ? sat_add(tile_reg[NST-1].green, add)
                                         : tile_reg[NST-1].green;
        o_tile_next.blue  = chan_mask[2] ? sat_add(tile_reg[NST-1].blue, add)
                                         : tile_reg[NST-1].blue;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            o_valid_reg <= 1'b0;
        end else if (o_rdy) begin
            o_valid_reg <= valid_reg[NST-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (o_rdy && valid_reg[NST-1]) o_tile_reg <= o_tile_next;
    end

    assign out_valid = o_valid_reg;
    assign out_tile  = o_tile_reg;

endmodule

### hdl/point_light_tile_tint.sv
// Top level of the point light tile tint block: configuration registers and pipeline.
//
//   Channel  Direction  Word
//   s_       in         tile visit: column, row, corner height, red, green, blue
//   m_       out        tinted colour and in-range flag
//   cfg_     in         light register write, no read-back
//
// One word is taken every cycle while the output is not held; a taken word passes
// through three distance stages, eight square-root stages of two root bits each,
// a range-test stage, four divider stages of up to two quotient bits each, and
// the output register.
// Reset clears every valid bit and sets the light registers to zero, colour white.
// Each stage holds its word while the next is full and held, and empty stages fill up
// under a stall, so nothing is dropped or repeated.
module point_light_tile_tint (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // tile_col, tile_row, corner_height, red_in, green_in, blue_in, zero fill
    input  logic [plt_pkg::S_TDATA_W-1:0]     s_tdata,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // red_out, green_out, blue_out, in_range, zero fill
    output logic [plt_pkg::M_TDATA_W-1:0]     m_tdata,
    input  logic                              cfg_wr_en,
    input  logic [plt_pkg::CFG_ADDR_W-1:0]    cfg_addr,
    input  logic [plt_pkg::CFG_W-1:0]         cfg_wdata
);

    plt_pkg::light_t                light_reg;
    plt_pkg::tile_t                 in_tile;
    logic                           d_valid, d_ready;
    logic [plt_pkg::SUM_W-1:0]      d_sum;
    plt_pkg::tile_t                 d_tile;
    logic                           r_valid, r_ready;
    logic [plt_pkg::DIST_W-1:0]     r_dist;
    plt_pkg::tile_t                 r_tile;
    plt_pkg::tile_t                 o_tile;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            light_reg.light_x      <= '0;
            light_reg.light_height <= '0;
            light_reg.light_z      <= '0;
            light_reg.light_range  <= '0;
            light_reg.light_hue    <= plt_pkg::COLOUR_WHITE;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                plt_pkg::CFG_LIGHT_X:
                    light_reg.light_x <= cfg_wdata[plt_pkg::LX_W-1:0];
                plt_pkg::CFG_LIGHT_HEIGHT:
                    light_reg.light_height <= cfg_wdata[plt_pkg::LH_W-1:0];
                plt_pkg::CFG_LIGHT_Z:
                    light_reg.light_z <= cfg_wdata[plt_pkg::LZ_W-1:0];
                plt_pkg::CFG_LIGHT_RANGE:
                    light_reg.light_range <= cfg_wdata[plt_pkg::RNG_W-1:0];
                plt_pkg::CFG_LIGHT_COLOUR:
                    light_reg.light_hue <= cfg_wdata[plt_pkg::COLOUR_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        in_tile.live  = 1'b0;
        in_tile.red   = s_tdata[37:30];
        in_tile.green = s_tdata[45:38];
        in_tile.blue  = s_tdata[53:46];
    end

    plt_dist u_dist (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .light     (light_reg),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_col    (s_tdata[7:0]),
        .in_row    (s_tdata[15:8]),
        .in_height (s_tdata[29:16]),
        .in_tile   (in_tile),
        .out_valid (d_valid),
        .out_ready (d_ready),
        .out_sum   (d_sum),
        .out_tile  (d_tile)
    );

    plt_sqrt u_sqrt (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (d_valid),
        .in_ready  (d_ready),
        .in_sum    (d_sum),
        .in_tile   (d_tile),
        .out_valid (r_valid),
        .out_ready (r_ready),
        .out_dist  (r_dist),
        .out_tile  (r_tile)
    );

    plt_quot u_quot (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .light     (light_reg),
        .in_valid  (r_valid),
        .in_ready  (r_ready),
        .in_dist   (r_dist),
        .in_tile   (r_tile),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_tile  (o_tile)
    );

    assign m_tdata = {7'b0, o_tile.live, o_tile.blue, o_tile.green, o_tile.red};

endmodule

### hdl/plt_checker.sv
// Port-level checker for the point light tile tint block, with its bind statement.
module plt_checker (
    input logic                             aclk,
    input logic                             aresetn,
    input logic                             s_tvalid,
    input logic                             s_tready,
    input logic                             m_tvalid,
    input logic                             m_tready,
    input logic [plt_pkg::M_TDATA_W-1:0]    m_tdata
);

    localparam int CNT_W = $clog2(plt_pkg::PIPE_DEPTH + 2);

    logic [CNT_W-1:0] inflight_reg, inflight_next;
    logic             in_acc, out_acc;

    assign in_acc  = s_tvalid && s_tready;
    assign out_acc = m_tvalid && m_tready;

    always_comb begin
        inflight_next = inflight_reg;
        if (in_acc && !out_acc) inflight_next = inflight_reg + CNT_W'(1);
        if (out_acc && !in_acc) inflight_next = inflight_reg - CNT_W'(1);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) inflight_reg <= '0;
        else          inflight_reg <= inflight_next;
    end

    // No result word may appear unless a tile word is still owed.
    a_no_phantom: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> inflight_reg != '0)
        else $error("result word with no tile word outstanding");

    a_depth: assert property (@(posedge aclk) disable iff (!aresetn)
        32'(inflight_reg) <= plt_pkg::PIPE_DEPTH)
        else $error("more words in flight than pipeline stages");

    // An empty or draining output register lets every stage load.
    a_ready_chain: assert property (@(posedge aclk) disable iff (!aresetn)
        (!m_tvalid || m_tready) |-> s_tready)
        else $error("input stalled while the output can move");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result word changed while held");

    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid straight after reset");

endmodule

bind point_light_tile_tint plt_checker u_plt_checker (.*);

### sim/point_light_tile_tint_checker.sv
`timescale 1ns / 1ps
// Checker for the point light tile tint block: predicts every tinted tile and compares results.
module point_light_tile_tint_checker (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    input  logic                           s_tready,
    input  logic [plt_pkg::S_TDATA_W-1:0]  s_tdata,
    input  logic                           m_tvalid,
    input  logic                           m_tready,
    input  logic [plt_pkg::M_TDATA_W-1:0]  m_tdata,
    input  logic                           cfg_wr_en,
    input  logic [plt_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [plt_pkg::CFG_W-1:0]      cfg_wdata,
    output int                             mismatches,
    output int                             outstanding
);

    localparam int CH_W = plt_pkg::CH_W;

    // Bit offsets of the fields in the input word, lowest first.
    localparam int ROW_LO = plt_pkg::COL_W;
    localparam int HGT_LO = ROW_LO + plt_pkg::ROW_W;
    localparam int RED_LO = HGT_LO + plt_pkg::HGT_W;
    localparam int GRN_LO = RED_LO + CH_W;
    localparam int BLU_LO = GRN_LO + CH_W;

    typedef struct packed {
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
        logic            lit;
    } tint_t;

    plt_pkg::light_t light;
    tint_t           expected_tints[$];

    initial begin
        mismatches  = 0;
        outstanding = 0;
    end

    function automatic logic [CH_W-1:0] brighten(input logic [CH_W-1:0] level,
                                                 input int unsigned boost);
        int unsigned sum;
        sum = level + boost;
        return (sum > plt_pkg::CH_MAX) ? CH_W'(plt_pkg::CH_MAX) : CH_W'(sum);
    endfunction

    function automatic tint_t tint_tile(input logic [plt_pkg::S_TDATA_W-1:0] word);
        logic [plt_pkg::COL_W-1:0] col;
        logic [plt_pkg::ROW_W-1:0] row;
        logic [plt_pkg::HGT_W-1:0] hgt;
        longint unsigned  corner_x, corner_z, dx, dy, dz, dist_sq, root, trial;
        int unsigned      boost;
        tint_t            t;
        col     = word[plt_pkg::COL_W-1:0];
        row     = word[ROW_LO +: plt_pkg::ROW_W];
        hgt     = word[HGT_LO +: plt_pkg::HGT_W];
        t.red   = word[RED_LO +: CH_W];
        t.green = word[GRN_LO +: CH_W];
        t.blue  = word[BLU_LO +: CH_W];
        t.lit   = 1'b0;

        corner_x = longint'(col) * plt_pkg::TILE_SIZE;
        corner_z = longint'(row) * plt_pkg::TILE_SIZE;
        dx = (corner_x > light.light_x) ? corner_x - light.light_x : light.light_x - corner_x;
        dy = (hgt > light.light_height) ? hgt - light.light_height : light.light_height - hgt;
        dz = (corner_z > light.light_z) ? corner_z - light.light_z : light.light_z - corner_z;
        dist_sq = dx * dx + dy * dy + dz * dz;

        // Floor square root, one root bit at a time from the top.
        root = 0;
        for (int k = 17; k >= 0; k--) begin
            trial = root | (64'd1 << k);
            if (trial * trial <= dist_sq) begin
                root = trial;
            end
        end

        if (col < plt_pkg::MAP_SIDE && row < plt_pkg::MAP_SIDE &&
            root < light.light_range) begin
            boost = plt_pkg::TINT_GAIN * (plt_pkg::ATTEN_SCALE -
                    int'(root * plt_pkg::ATTEN_SCALE / light.light_range));
            t.lit = 1'b1;
            case (light.light_hue)
                plt_pkg::COLOUR_RED: begin
                    t.red = brighten(t.red, boost);
                end
                plt_pkg::COLOUR_GREEN: begin
                    t.green = brighten(t.green, boost);
                end
                plt_pkg::COLOUR_BLUE: begin
                    t.blue = brighten(t.blue, boost);
                end
                plt_pkg::COLOUR_YELLOW: begin
                    t.red   = brighten(t.red, boost);
                    t.green = brighten(t.green, boost);
                end
                plt_pkg::COLOUR_WHITE: begin
                    t.red   = brighten(t.red, boost);
                    t.green = brighten(t.green, boost);
                    t.blue  = brighten(t.blue, boost);
                end
                default: begin
                end
            endcase
        end
        return t;
    endfunction

    task automatic check_field(input string field, input int want, input int got);
        if (want != got) begin
            $display("%0t: %s expected %0d, got %0d", $time, field, want, got);
            mismatches++;
        end
    endtask

    always @(posedge aclk) begin
        tint_t seen, want;
        if (!aresetn) begin
            light.light_x      = '0;
            light.light_height = '0;
            light.light_z      = '0;
            light.light_range  = '0;
            light.light_hue    = plt_pkg::COLOUR_WHITE;
            expected_tints.delete();
        end else begin
            if (cfg_wr_en) begin
                case (cfg_addr)
                    plt_pkg::CFG_LIGHT_X:
                        light.light_x      = cfg_wdata[plt_pkg::LX_W-1:0];
                    plt_pkg::CFG_LIGHT_HEIGHT:
                        light.light_height = cfg_wdata[plt_pkg::LH_W-1:0];
                    plt_pkg::CFG_LIGHT_Z:
                        light.light_z      = cfg_wdata[plt_pkg::LZ_W-1:0];
                    plt_pkg::CFG_LIGHT_RANGE:
                        light.light_range  = cfg_wdata[plt_pkg::RNG_W-1:0];
                    plt_pkg::CFG_LIGHT_COLOUR:
                        light.light_hue    = cfg_wdata[plt_pkg::COLOUR_W-1:0];
                    default: begin
                    end
                endcase
            end
            // Results are checked before this edge's input word is queued, since a word
            // taken now cannot leave in the same cycle.
            if (m_tvalid && m_tready) begin
                seen = '{red: m_tdata[CH_W-1:0], green: m_tdata[CH_W +: CH_W],
                         blue: m_tdata[2*CH_W +: CH_W], lit: m_tdata[3*CH_W]};
                if (expected_tints.size() == 0) begin
                    $display("%0t: result with none expected, expected nothing, got %h",
                             $time, m_tdata);
                    mismatches++;
                end else begin
                    want = expected_tints.pop_front();
                    check_field("red_out", want.red, seen.red);
                    check_field("green_out", want.green, seen.green);
                    check_field("blue_out", want.blue, seen.blue);
                    check_field("in_range", want.lit, seen.lit);
                end
            end
            if (s_tvalid && s_tready) begin
                expected_tints.push_back(tint_tile(s_tdata));
            end
        end
        outstanding = expected_tints.size();
    end

endmodule

### sim/point_light_tile_tint_tb.sv
`timescale 1ns / 1ps
// Testbench top for the point light tile tint block: clock, reset, stimulus and verdict.
module point_light_tile_tint_tb;

    localparam int CLK_HALF_NS   = 6;
    localparam int RESET_CYCLES  = 9;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int IDLE_PCT      = 18;
    localparam int RANDOM_PHASES = 14;
    localparam int PHASE_ITEMS   = 100;

    localparam int TILE_SIZE  = plt_pkg::TILE_SIZE;
    localparam int CH_MAX     = plt_pkg::CH_MAX;
    localparam int COL_W      = plt_pkg::COL_W;
    localparam int ROW_W      = plt_pkg::ROW_W;
    localparam int HGT_W      = plt_pkg::HGT_W;
    localparam int CH_W       = plt_pkg::CH_W;
    localparam int COLOUR_W   = plt_pkg::COLOUR_W;
    localparam int CFG_W      = plt_pkg::CFG_W;
    localparam int CFG_ADDR_W = plt_pkg::CFG_ADDR_W;
    localparam int S_TDATA_W  = plt_pkg::S_TDATA_W;
    localparam int M_TDATA_W  = plt_pkg::M_TDATA_W;

    localparam int MAX_COL    = (1 << COL_W) - 1;
    localparam int MAX_ROW    = (1 << ROW_W) - 1;
    localparam int MAX_HGT    = (1 << HGT_W) - 1;
    localparam int MAX_LX     = (1 << plt_pkg::LX_W) - 1;
    localparam int MAX_LH     = (1 << plt_pkg::LH_W) - 1;
    localparam int MAX_LZ     = (1 << plt_pkg::LZ_W) - 1;
    localparam int MAX_RNG    = (1 << plt_pkg::RNG_W) - 1;
    localparam int MAX_COLOUR = (1 << COLOUR_W) - 1;
    localparam int MAX_ADDR   = (1 << CFG_ADDR_W) - 1;

    localparam logic [COLOUR_W-1:0]   COLOUR_FIRST_UNUSED = plt_pkg::COLOUR_WHITE + 1'b1;
    localparam logic [CFG_ADDR_W-1:0] CFG_FIRST_UNUSED    = plt_pkg::CFG_LIGHT_COLOUR + 1'b1;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata   = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr  = plt_pkg::CFG_LIGHT_X;
    logic [CFG_W-1:0]      cfg_wdata = '0;

    int mismatches;
    int outstanding;
    int cycles = 0;
    bit steady = 1'b0;

    // Light as last written, used to aim tile visits near it.
    int light_x, light_h, light_z, light_range;

    point_light_tile_tint dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    point_light_tile_tint_checker tint_check (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wdata   (cfg_wdata),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    always begin
        #CLK_HALF_NS aclk = 1'b1;
        #CLK_HALF_NS aclk = 1'b0;
    end

    always @(negedge aclk) begin
        m_tready = steady || ($urandom_range(99) >= IDLE_PCT);
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    function automatic int clip(input int value, input int top);
        return (value < 0) ? 0 : (value > top) ? top : value;
    endfunction

    // Channel levels lean towards the ends so that saturation is hit often.
    function automatic int channel();
        case ($urandom_range(9))
            0:       return 0;
            1:       return CH_MAX;
            default: return $urandom_range(CH_MAX);
        endcase
    endfunction

    function automatic int pick(input int top);
        case ($urandom_range(5))
            0:       return 0;
            1:       return top;
            default: return $urandom_range(top);
        endcase
    endfunction

    function automatic int pick_reach();
        case ($urandom_range(7))
            0:       return 0;
            1:       return 1;
            2:       return MAX_RNG;
            3, 4:    return $urandom_range(1000, 1);
            default: return $urandom_range(MAX_RNG, 1);
        endcase
    endfunction

    task automatic write_reg(input logic [CFG_ADDR_W-1:0] index, input int value);
        cfg_wr_en = 1'b1;
        cfg_addr  = index;
        cfg_wdata = CFG_W'(value);
        @(negedge aclk);
    endtask

    task automatic wait_drained();
        s_tvalid = 1'b0;
        while (outstanding != 0) begin
            @(negedge aclk);
        end
    endtask

    // Every change of light ends with a write to an unused index, which must be ignored.
    task automatic set_light(input int x, input int h, input int z, input int reach,
                             input logic [COLOUR_W-1:0] colour);
        wait_drained();
        light_x     = x;
        light_h     = h;
        light_z     = z;
        light_range = reach;
        write_reg(plt_pkg::CFG_LIGHT_X, x);
        write_reg(plt_pkg::CFG_LIGHT_HEIGHT, h);
        write_reg(plt_pkg::CFG_LIGHT_Z, z);
        write_reg(plt_pkg::CFG_LIGHT_RANGE, reach);
        write_reg(plt_pkg::CFG_LIGHT_COLOUR, colour);
        write_reg(CFG_ADDR_W'($urandom_range(MAX_ADDR, CFG_FIRST_UNUSED)), $urandom);
        cfg_wr_en = 1'b0;
    endtask

    task automatic visit(input int col, input int row, input int hgt,
                         input int red, input int green, input int blue);
        while (!steady && $urandom_range(99) < IDLE_PCT) begin
            s_tvalid = 1'b0;
            @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tdata  = S_TDATA_W'({CH_W'(blue), CH_W'(green), CH_W'(red),
                               HGT_W'(hgt), ROW_W'(row), COL_W'(col)});
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
    endtask

    task automatic random_visit();
        int reach_tiles, col, row, hgt;
        if ($urandom_range(99) < 75) begin
            reach_tiles = light_range / TILE_SIZE + 2;
            col = clip(light_x / TILE_SIZE + int'($urandom_range(2 * reach_tiles)) - reach_tiles,
                       MAX_COL);
            row = clip(light_z / TILE_SIZE + int'($urandom_range(2 * reach_tiles)) - reach_tiles,
                       MAX_ROW);
            hgt = clip(light_h + int'($urandom_range(2 * light_range + 2)) - light_range - 1,
                       MAX_HGT);
        end else begin
            col = $urandom_range(MAX_COL);
            row = $urandom_range(MAX_ROW);
            hgt = $urandom_range(MAX_HGT);
        end
        visit(col, row, hgt, channel(), channel(), channel());
    endtask

    initial begin
        repeat (RESET_CYCLES) @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        // Light as it comes out of reset has zero range, so nothing is lit.
        visit(0, 0, 0, 0, 0, 0);
        visit(MAX_COL, MAX_ROW, MAX_HGT, CH_MAX, CH_MAX, CH_MAX);

        set_light(0, 0, 0, MAX_RNG, plt_pkg::COLOUR_WHITE);
        visit(0, 0, 0, 0, 0, 0);
        visit(0, 0, 0, CH_MAX, CH_MAX, CH_MAX);
        visit(0, 0, MAX_HGT, 55, 56, 57);
        visit(1, 0, 0, 10, 20, 30);
        visit(MAX_COL, MAX_ROW, MAX_HGT, 1, 2, 3);

        set_light(MAX_LX, MAX_LH, MAX_LZ, 1, plt_pkg::COLOUR_GREEN);
        visit(MAX_COL, MAX_ROW, MAX_HGT, 9, 9, 9);

        // A range of one lights only the corner that sits exactly on the light.
        set_light(MAX_COL * TILE_SIZE, MAX_LH, MAX_ROW * TILE_SIZE, 1, plt_pkg::COLOUR_RED);
        visit(MAX_COL, MAX_ROW, MAX_HGT, 100, 100, 100);
        visit(MAX_COL, MAX_ROW, MAX_HGT - 1, 100, 100, 100);

        // Distance equal to the range is out; one short of it gets the smallest boost.
        set_light(10 * TILE_SIZE, 100, 10 * TILE_SIZE, 500, plt_pkg::COLOUR_YELLOW);
        visit(10, 10, 100, 40, 200, 90);
        visit(10, 10, 600, 40, 200, 90);
        visit(10, 10, 599, 40, 200, 90);
        visit(11, 10, 100, 40, 200, 90);

        set_light(10 * TILE_SIZE, 100, 10 * TILE_SIZE, 500, plt_pkg::COLOUR_BLUE);
        visit(10, 10, 100, 60, 60, CH_MAX);

        // Unknown colour codes leave the colour alone but still report the range test.
        for (int c = COLOUR_FIRST_UNUSED; c <= MAX_COLOUR; c++) begin
            set_light(10 * TILE_SIZE, 100, 10 * TILE_SIZE, 500, COLOUR_W'(c));
            visit(10, 10, 100, 7, 8, 9);
        end

        for (int p = 0; p < RANDOM_PHASES; p++) begin
            set_light(pick(MAX_LX), pick(MAX_LH), pick(MAX_LZ), pick_reach(),
                      COLOUR_W'($urandom_range(MAX_COLOUR)));
            steady = (p == 2);
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                if (p == 5 && i == PHASE_ITEMS / 2) begin
                    wait_drained();
                end
                random_visit();
            end
        end
        steady = 1'b0;

        wait_drained();
        repeat (plt_pkg::PIPE_DEPTH + 8) @(negedge aclk);
        if (mismatches == 0 && outstanding == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

### point_light_tile_tint.f
hdl/plt_pkg.sv
hdl/plt_dist.sv
hdl/plt_sqrt.sv
hdl/plt_quot.sv
hdl/point_light_tile_tint.sv
hdl/plt_checker.sv
sim/point_light_tile_tint_checker.sv
sim/point_light_tile_tint_tb.sv
